### hdl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// shared types and fixed field widths of the clock page replacement core
// ----------------------------------------------------------------------------
package cpr_pkg;

  // fixed widths of the stream and configuration fields
  localparam int unsigned PAGE_PORT_W = 16;
  localparam int unsigned FRAME_IDX_W = 4;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned FAULT_W     = 32;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // item kinds carried on tuser
  localparam logic KIND_REFERENCE = 1'b0;
  localparam logic KIND_PRELOAD   = 1'b1;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_FILL      = 6'b000010,
    S_LOOK      = 6'b000100,
    S_SWEEP_RD  = 6'b001000,
    S_SWEEP_CHK = 6'b010000,
    S_OUT       = 6'b100000
  } state_t;

endpackage

### hdl/clock_page_replacement_core.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_core
// second-chance (clock) page replacement over a ram-held frame table
// ----------------------------------------------------------------------------
// steps: a preload probes frames from the fill point, skipping occupied ones;
//   a lookup compares the active frames in turn; a fault then sweeps the hand,
//   each frame taking a ram read state and a check/write-back state
// throughput: one item at a time; a new word is taken while the last result
//   still waits in the output register
// reset: synchronous, active high; clears the occupied bits, hand, preload
//   fill, fault counter and sets frames_in_use to FRAME_COUNT; the frame ram
//   needs no clearing since an empty frame is never read for its contents
// ----------------------------------------------------------------------------
module clock_page_replacement_core
  import cpr_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = 16,
  parameter int unsigned PAGE_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,

  // configuration write: frames_in_use
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,

  // input words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] page_number, [16] is_write, [23:17] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                   s_axis_tuser,

  // result words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] hit, [1] fault, [5:2] frame_index, [6] evicted_valid,
  // [22:7] evicted_page, [23] evicted_dirty, [24] preload_refused,
  // [56:25] fault_total, [63:57] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // widths derived from the parameters
  localparam int unsigned AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned CW = $clog2(FRAME_COUNT + 1);
  localparam int unsigned NW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned PW = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
  localparam int unsigned EW = PW + 2;  // ram entry: {page, referenced, dirty}

  // configuration and control state
  state_t                 state;
  logic [NW-1:0]          frames_in_use;
  logic [FRAME_COUNT-1:0] occupied;
  logic [AW-1:0]          hand;
  logic [CW-1:0]          fill;
  logic [FAULT_W-1:0]     fault_counter;

  // current item
  logic [PW-1:0]          page;
  logic                   wr;

  // scan pointers
  logic [CW-1:0]          scan;      // lookup issue address / preload probe
  logic                   cmp_valid; // ram data for cmp_addr arrives this cycle
  logic [AW-1:0]          cmp_addr;

  // result being built
  logic                   res_hit;
  logic                   res_fault;
  logic [AW-1:0]          res_frame;
  logic                   res_ev_valid;
  logic [PW-1:0]          res_ev_page;
  logic                   res_ev_dirty;
  logic                   res_refused;

  // output register
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  // frame ram ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [PW-1:0]          rd_page;
  logic                   rd_ref;
  logic                   rd_dirty;

  // active frame count, clamped to 1..FRAME_COUNT
  logic [NW-1:0]          cfg_ext;
  logic [NW-1:0]          n_wide;
  logic [CW-1:0]          active_n;

  // combinational controls
  logic                   take;
  logic                   issuing;
  logic                   match;
  logic [CW-1:0]          hand_inc;
  logic [AW-1:0]          hand_wrap;
  logic                   out_free;

  assign cfg_ext = frames_in_use;

  always_comb begin
    if (cfg_ext == '0) begin
      n_wide = NW'(1);
    end else if (cfg_ext > NW'(FRAME_COUNT)) begin
      n_wide = NW'(FRAME_COUNT);
    end else begin
      n_wide = cfg_ext;
    end
  end

  assign active_n = n_wide[CW-1:0];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign take          = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign out_free      = !out_valid || m_axis_tready;

  assign rd_page  = ram_rdata[EW-1:2];
  assign rd_ref   = ram_rdata[1];
  assign rd_dirty = ram_rdata[0];

  // lookup pipeline: one ram read issued per cycle, compared in the cycle after
  assign issuing = (scan < active_n);
  assign match   = cmp_valid && occupied[cmp_addr] && (rd_page == page);

  // hand step with wrap at the active count
  assign hand_inc  = CW'(hand) + CW'(1);
  assign hand_wrap = (hand_inc >= active_n) ? '0 : hand_inc[AW-1:0];

  // ram addressing and write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hand;
    ram_wdata = {page, 1'b1, wr};
    ram_raddr = hand;
    case (state)
      S_FILL: begin
        ram_waddr = scan[AW-1:0];
        ram_we    = issuing && !occupied[scan[AW-1:0]];
      end
      S_LOOK: begin
        ram_raddr = scan[AW-1:0];
        ram_waddr = cmp_addr;
        if (match) begin
          // hit: mark referenced, dirty on a write
          ram_we    = 1'b1;
          ram_wdata = {rd_page, 1'b1, rd_dirty | wr};
        end
      end
      S_SWEEP_CHK: begin
        ram_we = 1'b1;
        if (occupied[hand] && rd_ref) begin
          // second chance: clear the reference bit and move on
          ram_wdata = {rd_page, 1'b0, rd_dirty};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cpr_ram #(
    .WIDTH (EW),
    .DEPTH (FRAME_COUNT)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_in_use <= NW'(FRAME_COUNT);
      occupied      <= '0;
      hand          <= '0;
      fill          <= '0;
      fault_counter <= '0;
      cmp_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_in_use <= NW'(cfg_data);
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (take) begin
            page         <= s_axis_tdata[PW-1:0];
            wr           <= s_axis_tdata[PAGE_PORT_W];
            res_hit      <= 1'b0;
            res_fault    <= 1'b0;
            res_frame    <= '0;
            res_ev_valid <= 1'b0;
            res_ev_page  <= '0;
            res_ev_dirty <= 1'b0;
            res_refused  <= 1'b0;
            cmp_valid    <= 1'b0;
            if (s_axis_tuser == KIND_PRELOAD) begin
              scan  <= fill;
              state <= S_FILL;
            end else begin
              scan  <= '0;
              state <= S_LOOK;
            end
          end
        end

        S_FILL: begin
          // probe one occupied bit a cycle from the fill point
          if (!issuing) begin
            res_refused <= 1'b1;
            state       <= S_OUT;
          end else if (!occupied[scan[AW-1:0]]) begin
            occupied[scan[AW-1:0]] <= 1'b1;
            fill      <= scan + CW'(1);
            res_frame <= scan[AW-1:0];
            state     <= S_OUT;
          end else begin
            scan <= scan + CW'(1);
          end
        end

        S_LOOK: begin
          cmp_valid <= issuing && !match;
          cmp_addr  <= scan[AW-1:0];
          if (issuing) begin
            scan <= scan + CW'(1);
          end
          if (match) begin
            res_hit   <= 1'b1;
            res_frame <= cmp_addr;
            state     <= S_OUT;
          end else if (!issuing && cmp_valid) begin
            // last active frame compared without a match: page fault
            res_fault <= 1'b1;
            if (fault_counter != FAULT_MAX) begin
              fault_counter <= fault_counter + FAULT_W'(1);
            end
            if (CW'(hand) >= active_n) begin
              hand <= '0;
            end
            state <= S_SWEEP_RD;
          end
        end

        S_SWEEP_RD: begin
          state <= S_SWEEP_CHK;
        end

        S_SWEEP_CHK: begin
          if (occupied[hand] && rd_ref) begin
            hand  <= hand_wrap;
            state <= S_SWEEP_RD;
          end else begin
            // empty or unreferenced frame: the new page goes here
            if (occupied[hand]) begin
              res_ev_valid <= 1'b1;
              res_ev_page  <= rd_page;
              res_ev_dirty <= rd_dirty;
            end
            occupied[hand] <= 1'b1;
            res_frame      <= hand;
            hand           <= hand_wrap;
            state          <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word, loaded as the sequencer leaves the output state
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= {
        7'b0,
        fault_counter,
        res_refused,
        res_ev_dirty,
        PAGE_PORT_W'(res_ev_page),
        res_ev_valid,
        FRAME_IDX_W'(res_frame),
        res_fault,
        res_hit
      };
    end
  end

endmodule

### hdl/cpr_ram.sv
// ----------------------------------------------------------------------------
// cpr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
